[rtl/pit_clr_pkg.sv]
// Package for the interval timer counter readback block.
// Holds the request kind codes, port addresses, byte pointer codes and register indexes.
// No dependencies.
package pit_clr_pkg;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_INJECT = 2'd1,
        OP_ACCESS = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Byte pointer codes
    typedef enum logic [1:0] {
        BP_LOW       = 2'd0,
        BP_HIGH      = 2'd1,
        BP_PAIR_LOW  = 2'd2,
        BP_PAIR_HIGH = 2'd3
    } bptr_t;

    // Configuration register indexes
    localparam logic [1:0] REG_INITIAL_COUNT   = 2'd0;
    localparam logic [1:0] REG_COUNTER_CHANNEL = 2'd1;
    localparam logic [1:0] REG_ACCESS_MODE     = 2'd2;

    // I/O ports
    localparam logic [15:0] PORT_MODE = 16'h0043;
    localparam logic [15:0] PORT_BASE = 16'h0040;

    // Reload value used when the initial count is zero
    localparam logic [16:0] RELOAD_FULL = 17'h10000;

endpackage

[rtl/pit_counter_latch_readback.sv]
// Counter readback with latching for one channel of an 8254-style interval timer.
// Holds the count state, the latch logic and a bit-serial remainder unit.
// Depends on pit_clr_pkg.
//
// The result of an accepted request is registered in the output register.
// One request per cycle while the output side takes results and no remainder pass runs.
// A write of initial_count starts a remainder pass (one bit per cycle) that
// reduces the elapsed count modulo the new reload value; requests and configuration
// writes are held off until the pass ends.
// Reset (asynchronous, rst_n low): initial count 0, channel 0, elapsed count 0,
// latches clear, byte pointer at low of a pair as for access mode 3, no result pending.
module pit_counter_latch_readback
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] port, [16] is_read, [19:17] access_size, [20] string_mode,
    // [21] port_io, [29:22] write_data, [31:30] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data
    output logic [7:0]  m_axis_tdata,
    // [0] handled
    output logic        m_axis_tuser
);

    // Configuration registers
    logic [15:0] initial_count_reg;
    logic [1:0]  channel_reg;

    // Count state
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] mod_reg, mod_next;
    logic [15:0] held_reg, held_next;
    logic        low_latched_reg, low_latched_next;
    logic        high_latched_reg, high_latched_next;
    logic [1:0]  bptr_reg, bptr_next;

    // Remainder unit
    logic        div_busy_reg;
    logic [3:0]  div_cnt_reg;
    logic [15:0] div_dvd_reg;
    logic [16:0] div_rem_reg;
    logic [17:0] div_shift;
    logic [16:0] div_rem_step;

    // Output register
    logic        out_valid_reg;
    logic        out_handled_reg, out_handled_next;
    logic [7:0]  out_data_reg, out_data_next;

    // Request fields
    logic [1:0]  op;
    logic [15:0] port;
    logic        is_read;
    logic [2:0]  access_size;
    logic        string_mode;
    logic        port_io;
    logic [7:0]  write_data;

    logic        in_fire;
    logic        cfg_fire;
    logic [16:0] reload;
    logic [16:0] tick_sum;
    logic [15:0] live_count;
    logic        access_ok;
    logic        is_latch;
    logic        is_read_hit;
    logic        read_low;
    logic [15:0] read_src;

    assign op          = s_axis_tuser;
    assign port        = s_axis_tdata[15:0];
    assign is_read     = s_axis_tdata[16];
    assign access_size = s_axis_tdata[19:17];
    assign string_mode = s_axis_tdata[20];
    assign port_io     = s_axis_tdata[21];
    assign write_data  = s_axis_tdata[29:22];

    // Handshakes
    assign s_axis_tready = !div_busy_reg && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = !div_busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = cfg_valid && cfg_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_handled_reg;

    // Reload value and live count
    assign reload     = (initial_count_reg == 16'd0) ? pit_clr_pkg::RELOAD_FULL
                                                     : {1'b0, initial_count_reg};
    assign tick_sum   = {1'b0, elapsed_reg} + 17'd1;
    assign live_count = 16'(reload - {1'b0, mod_reg});

    // Decode the access
    assign access_ok   = (op == pit_clr_pkg::OP_ACCESS) && (access_size == 3'd1)
                         && !string_mode && port_io;
    assign is_latch    = access_ok && (port == pit_clr_pkg::PORT_MODE) && !is_read
                         && (write_data[5:4] == 2'd0) && (write_data[7:6] == channel_reg);
    assign is_read_hit = access_ok && !is_latch && is_read
                         && (port == (pit_clr_pkg::PORT_BASE + {14'd0, channel_reg}));

    // Pick the byte to return on a read
    always_comb
    begin
        if (low_latched_reg)
        begin
            read_low = 1'b1;
            read_src = held_reg;
        end
        else if (high_latched_reg)
        begin
            read_low = 1'b0;
            read_src = held_reg;
        end
        else
        begin
            read_low = !bptr_reg[0];
            read_src = live_count;
        end
    end

    // Advance the count state for one request
    always_comb
    begin
        elapsed_next      = elapsed_reg;
        mod_next          = mod_reg;
        held_next         = held_reg;
        low_latched_next  = low_latched_reg;
        high_latched_next = high_latched_reg;
        bptr_next         = bptr_reg;
        out_handled_next  = 1'b0;
        out_data_next     = 8'd0;

        if (in_fire)
        begin
            case (op)
                pit_clr_pkg::OP_TICK:
                begin
                    elapsed_next = (tick_sum >= reload) ? 16'd0 : tick_sum[15:0];
                    mod_next     = elapsed_next;
                end
                pit_clr_pkg::OP_INJECT:
                begin
                    elapsed_next = 16'd0;
                    mod_next     = 16'd0;
                end
                default:
                begin
                    if (is_latch)
                    begin
                        out_handled_next = 1'b1;
                        held_next        = live_count;
                        unique case (bptr_reg)
                            pit_clr_pkg::BP_LOW:  low_latched_next  = 1'b1;
                            pit_clr_pkg::BP_HIGH: high_latched_next = 1'b1;
                            default:
                            begin
                                bptr_next         = pit_clr_pkg::BP_PAIR_LOW;
                                low_latched_next  = 1'b1;
                                high_latched_next = 1'b1;
                            end
                        endcase
                    end
                    else if (is_read_hit)
                    begin
                        out_handled_next = 1'b1;
                        held_next        = read_src;
                        if (low_latched_reg)
                            low_latched_next = 1'b0;
                        else if (high_latched_reg)
                            high_latched_next = 1'b0;
                        if (read_low)
                        begin
                            out_data_next = read_src[7:0];
                            if (bptr_reg == pit_clr_pkg::BP_PAIR_LOW)
                                bptr_next = pit_clr_pkg::BP_PAIR_HIGH;
                        end
                        else
                        begin
                            out_data_next = read_src[15:8];
                            if (bptr_reg == pit_clr_pkg::BP_PAIR_HIGH)
                                bptr_next = pit_clr_pkg::BP_PAIR_LOW;
                        end
                    end
                end
            endcase
        end

        // Configuration writes
        if (cfg_fire)
        begin
            if (cfg_index == pit_clr_pkg::REG_INITIAL_COUNT)
            begin
                low_latched_next  = 1'b0;
                high_latched_next = 1'b0;
            end
            else if (cfg_index == pit_clr_pkg::REG_ACCESS_MODE && cfg_data[1:0] != 2'd0)
            begin
                bptr_next = cfg_data[1:0] - 2'd1;
            end
        end
    end

    // One restoring remainder step
    assign div_shift    = {div_rem_reg, div_dvd_reg[15]};
    assign div_rem_step = (div_shift >= {1'b0, reload}) ? 17'(div_shift - {1'b0, reload})
                                                        : div_shift[16:0];

    // Hold the configuration registers; the access mode only moves the byte pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_count_reg <= 16'd0;
            channel_reg       <= 2'd0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                pit_clr_pkg::REG_INITIAL_COUNT:   initial_count_reg <= cfg_data;
                pit_clr_pkg::REG_COUNTER_CHANNEL: channel_reg       <= cfg_data[1:0];
                default:                          ;
            endcase
        end
    end

    // Hold the count state and step the remainder unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg      <= 16'd0;
            mod_reg          <= 16'd0;
            held_reg         <= 16'd0;
            low_latched_reg  <= 1'b0;
            high_latched_reg <= 1'b0;
            bptr_reg         <= pit_clr_pkg::BP_PAIR_LOW;
            div_busy_reg     <= 1'b0;
            div_cnt_reg      <= 4'd0;
            div_dvd_reg      <= 16'd0;
            div_rem_reg      <= 17'd0;
        end
        else
        begin
            elapsed_reg      <= elapsed_next;
            held_reg         <= held_next;
            low_latched_reg  <= low_latched_next;
            high_latched_reg <= high_latched_next;
            bptr_reg         <= bptr_next;

            if (cfg_fire && cfg_index == pit_clr_pkg::REG_INITIAL_COUNT)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 4'd15;
                div_dvd_reg  <= elapsed_reg;
                div_rem_reg  <= 17'd0;
                mod_reg      <= mod_next;
            end
            else if (div_busy_reg)
            begin
                div_rem_reg <= div_rem_step;
                div_dvd_reg <= {div_dvd_reg[14:0], 1'b0};
                div_cnt_reg <= div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0)
                begin
                    div_busy_reg <= 1'b0;
                    mod_reg      <= div_rem_step[15:0];
                end
            end
            else
            begin
                mod_reg <= mod_next;
            end
        end
    end

    // Output register: load on a request, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_handled_reg <= out_handled_next;
            out_data_reg    <= out_data_next;
        end
    end

endmodule
